// ----- design/mpf_pkg.sv -----
package mpf_pkg;

  localparam logic [31:0] TOPIC_MAX   = 32'd255;
  localparam logic [31:0] PAYLOAD_MAX = 32'd4095;

  localparam logic [7:0] PUBLISH_HDR  = 8'h30;
  localparam logic [7:0] VARINT_MORE  = 8'h80;

  localparam int unsigned BURST_MAX = 5;
  localparam int unsigned CNT_W     = $clog2(BURST_MAX + 1);

  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_TOPIC   = 2'd1,
    FN_PAYLOAD = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TOPIC   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]               cnt;
    logic [BURST_MAX-1:0][7:0]      bytes;
    logic [BURST_MAX-1:0]           last;
  } burst_t;

endpackage

// ----- design/mqtt_publish_framer.sv -----
// Channel | Direction | Handshake               | Words
// in_     | input     | in_valid / in_stall     | func, topic_len, payload_len, data_byte
// out_    | output    | out_valid / out_stall   | out_byte, out_is_last
// cfg_    | input     | cfg_valid / cfg_ready   | connected
//
// With out_stall low, one item per cycle for topic and payload bytes; a start item emits 4 or 5 words,
// one per cycle, and stalls the input until its last word moves to the output register.
// Rate is set by the single output register draining the burst register.
// rst_n is synchronous, active low; clears phase, counters, connected and valids.
// out_stall holds the output word; in_stall rises while more than one burst word, or one stalled word, waits.
module mqtt_publish_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_topic_len,
  input  logic [11:0] in_payload_len,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_connected
);

  logic            connected_r, connected_nxt;
  logic            acc;
  logic            busy;
  mpf_pkg::burst_t burst;

  assign cfg_ready     = 1'b1;
  assign connected_nxt = (cfg_valid && cfg_ready) ? cfg_connected : connected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connected_r <= 1'b0;
    end else begin
      connected_r <= connected_nxt;
    end
  end

  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;

  mpf_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .connected   (connected_r),
    .acc         (acc),
    .func        (in_func),
    .topic_len   (in_topic_len),
    .payload_len (in_payload_len),
    .data_byte   (in_data_byte),
    .burst       (burst)
  );

  mpf_burst u_burst (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (acc),
    .burst       (burst),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_is_last (out_is_last),
    .out_stall   (out_stall)
  );

endmodule

// ----- design/mpf_frame.sv -----
module mpf_frame (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            connected,
  input  logic            acc,
  input  logic [1:0]      func,
  input  logic [7:0]      topic_len,
  input  logic [11:0]     payload_len,
  input  logic [7:0]      data_byte,
  output mpf_pkg::burst_t burst
);

  mpf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      topic_left_r, topic_left_nxt;
  logic [11:0]     payload_left_r, payload_left_nxt;

  logic            start_ok;
  logic            topic_ok;
  logic            payload_ok;
  logic [7:0]      topic_dec;
  logic [11:0]     payload_dec;
  logic [12:0]     rem;
  logic            two_digits;

  assign topic_dec   = topic_left_r - 8'd1;
  assign payload_dec = payload_left_r - 12'd1;

  assign start_ok = connected && (func == mpf_pkg::FN_START) && (phase_r == mpf_pkg::PH_IDLE)
                    && ({24'd0, topic_len} <= mpf_pkg::TOPIC_MAX)
                    && ({20'd0, payload_len} <= mpf_pkg::PAYLOAD_MAX);
  assign topic_ok   = connected && (func == mpf_pkg::FN_TOPIC) && (phase_r == mpf_pkg::PH_TOPIC);
  assign payload_ok = connected && (func == mpf_pkg::FN_PAYLOAD)
                      && (phase_r == mpf_pkg::PH_PAYLOAD);

  assign rem        = {5'd0, topic_len} + 13'd2 + {1'b0, payload_len};
  assign two_digits = (rem[12:7] != 6'd0);

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    topic_left_nxt   = topic_left_r;
    payload_left_nxt = payload_left_r;
    if (acc && start_ok) begin
      topic_left_nxt   = topic_len;
      payload_left_nxt = payload_len;
      if (topic_len != 8'd0) begin
        phase_nxt = mpf_pkg::PH_TOPIC;
      end else if (payload_len != 12'd0) begin
        phase_nxt = mpf_pkg::PH_PAYLOAD;
      end else begin
        phase_nxt = mpf_pkg::PH_IDLE;
      end
    end else if (acc && topic_ok) begin
      topic_left_nxt = topic_dec;
      if (topic_dec == 8'd0) begin
        phase_nxt = (payload_left_r != 12'd0) ? mpf_pkg::PH_PAYLOAD : mpf_pkg::PH_IDLE;
      end
    end else if (acc && payload_ok) begin
      payload_left_nxt = payload_dec;
      if (payload_dec == 12'd0) begin
        phase_nxt = mpf_pkg::PH_IDLE;
      end
    end
  end

  // burst of result words
  always_comb begin
    burst = '0;
    if (start_ok) begin
      burst.bytes[0] = mpf_pkg::PUBLISH_HDR;
      burst.bytes[1] = {1'b0, rem[6:0]} | (two_digits ? mpf_pkg::VARINT_MORE : 8'd0);
      if (two_digits) begin
        burst.bytes[2] = {2'b00, rem[12:7]};
        burst.bytes[3] = 8'd0;
        burst.bytes[4] = topic_len;
        burst.last[4]  = (topic_len == 8'd0) && (payload_len == 12'd0);
        burst.cnt      = mpf_pkg::CNT_W'(5);
      end else begin
        burst.bytes[2] = 8'd0;
        burst.bytes[3] = topic_len;
        burst.last[3]  = (topic_len == 8'd0) && (payload_len == 12'd0);
        burst.cnt      = mpf_pkg::CNT_W'(4);
      end
    end else if (topic_ok) begin
      burst.bytes[0] = data_byte;
      burst.last[0]  = (topic_dec == 8'd0) && (payload_left_r == 12'd0);
      burst.cnt      = mpf_pkg::CNT_W'(1);
    end else if (payload_ok) begin
      burst.bytes[0] = data_byte;
      burst.last[0]  = (payload_dec == 12'd0);
      burst.cnt      = mpf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= mpf_pkg::PH_IDLE;
      topic_left_r   <= 8'd0;
      payload_left_r <= 12'd0;
    end else begin
      phase_r        <= phase_nxt;
      topic_left_r   <= topic_left_nxt;
      payload_left_r <= payload_left_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_topic_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mpf_pkg::PH_TOPIC |-> topic_left_r != 8'd0)
    else $error("topic phase with no topic bytes left");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mpf_pkg::PH_PAYLOAD |-> payload_left_r != 12'd0)
    else $error("payload phase with no payload bytes left");
`endif

endmodule

// ----- design/mpf_burst.sv -----
module mpf_burst (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  mpf_pkg::burst_t burst,
  output logic            busy,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_is_last,
  input  logic            out_stall
);

  logic [mpf_pkg::CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [mpf_pkg::BURST_MAX-1:0][7:0]     byte_r, byte_nxt;
  logic [mpf_pkg::BURST_MAX-1:0]          last_r, last_nxt;
  logic                                   ov_r, ov_nxt;
  logic [7:0]                             ob_r, ob_nxt;
  logic                                   ol_r, ol_nxt;
  logic                                   out_free;
  logic                                   mv;

  assign out_free = !ov_r || !out_stall;
  assign mv       = out_free && (cnt_r != '0);
  assign busy     = (cnt_r > mpf_pkg::CNT_W'(1)) || ((cnt_r == mpf_pkg::CNT_W'(1)) && !out_free);

  always_comb begin
    cnt_nxt  = cnt_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (load) begin
      cnt_nxt  = burst.cnt;
      byte_nxt = burst.bytes;
      last_nxt = burst.last;
    end else if (mv) begin
      cnt_nxt  = cnt_r - mpf_pkg::CNT_W'(1);
      byte_nxt = {8'd0, byte_r[mpf_pkg::BURST_MAX-1:1]};
      last_nxt = {1'b0, last_r[mpf_pkg::BURST_MAX-1:1]};
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    if (mv) begin
      ov_nxt = 1'b1;
      ob_nxt = byte_r[0];
      ol_nxt = last_r[0];
    end else if (out_free) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid   = ov_r;
  assign out_byte    = ob_r;
  assign out_is_last = ol_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mpf_pkg::CNT_W'(mpf_pkg::BURST_MAX))
    else $error("burst count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == '0) || mv)
    else $error("burst loaded over pending words");

  a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
    mv |=> ov_r && (ob_r == $past(byte_r[0])))
    else $error("moved word not presented");
`endif

endmodule
